### src/wmf_pkg.sv
// Shared types and constants for the window median filter.
// No dependencies; every other file imports this package.
`default_nettype none

package wmf_pkg;

    localparam int PIX_W          = 8;
    localparam int WIN_FIELD_W    = 3;
    localparam int FRAME_W        = 11;
    localparam int ROW_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int FRAME_ROWS_MAX = 1024;
    localparam int OUT_DEPTH      = 32;
    localparam int CELL_LIM       = 225;

    localparam logic [WIN_FIELD_W-1:0] RESET_WINDOW = 3'd3;
    localparam logic [FRAME_W-1:0]     RESET_WIDTH  = 11'd640;
    localparam logic [FRAME_W-1:0]     RESET_HEIGHT = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic frame_end;
    } med_tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] median_value;
        logic             frame_end;
    } out_word_t;

    // Cells outside a k-by-k window: the first ones get 0, the rest 255, so that
    // the median of the full mw*mw array equals the median of the k*k window.
    function automatic logic [CELL_LIM-1:0] low_fill_mask(input int mw, input int k);
        logic [CELL_LIM-1:0] m;
        int                  u0;
        int                  seen;
        m    = '0;
        u0   = (mw * mw) / 2 - (k * k) / 2;
        seen = 0;
        for (int i = 0; i < mw; i++) begin
            for (int j = 0; j < mw; j++) begin
                if (i >= k || j >= k) begin
                    if (seen < u0) begin
                        m[i*mw+j] = 1'b1;
                    end
                    seen++;
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### src/wmf_pix_if.sv
// Input channel: pixel or drain word with valid/ready.
// Depends on wmf_pkg.
`default_nettype none

interface wmf_pix_if;
    import wmf_pkg::*;
    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, func, pixel_value, input ready);
    modport sink   (input valid, func, pixel_value, output ready);
endinterface

`default_nettype wire

### src/wmf_med_if.sv
// Output channel: median word with valid/ready.
// Depends on wmf_pkg.
`default_nettype none

interface wmf_med_if;
    import wmf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] median_value;
    logic             frame_end;

    modport source (output valid, median_value, frame_end, input ready);
    modport sink   (input valid, median_value, frame_end, output ready);
endinterface

`default_nettype wire

### src/wmf_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Depends on wmf_pkg.
`default_nettype none

interface wmf_cfg_if;
    import wmf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/wmf_median_sel.sv
// Pipelined bit-serial rank selector: picks the middle element of the cell array.
// Two stages per bit, MSB first. Depends on wmf_pkg.
`default_nettype none

module wmf_median_sel #(
    parameter int MAX_WINDOW = 7
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     in_valid,
    input  wmf_pkg::med_tag_t                                        in_tag,
    input  logic [MAX_WINDOW*MAX_WINDOW-1:0][wmf_pkg::PIX_W-1:0]     in_cells,
    output logic                                                     out_valid,
    output wmf_pkg::med_tag_t                                        out_tag,
    output logic [wmf_pkg::PIX_W-1:0]                                out_value
);
    import wmf_pkg::*;

    localparam int CELLS    = MAX_WINDOW * MAX_WINDOW;
    localparam int RANK_W   = $clog2(CELLS + 1);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int MED_RANK = CELLS / 2;

    typedef struct packed {
        logic [CELLS-1:0][PIX_W-1:0] val;
        logic [CELLS-1:0]            cand;
        logic [RANK_W-1:0]           rank;
        logic [PIX_W-1:0]            res;
        med_tag_t                    tag;
    } stage_t;

    stage_t                               st_reg     [PIX_W+1];
    logic                                 st_vld_reg [PIX_W+1];
    stage_t                               pc_reg     [PIX_W];
    logic                                 pc_vld_reg [PIX_W];
    logic [MAX_WINDOW-1:0][CNT_W-1:0]     cnt_reg    [PIX_W];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_vld_reg[0] <= 1'b0;
        end
        else begin
            st_vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        st_reg[0].val  <= in_cells;
        st_reg[0].cand <= '1;
        st_reg[0].rank <= RANK_W'(MED_RANK);
        st_reg[0].res  <= '0;
        st_reg[0].tag  <= in_tag;
    end

    for (genvar g = 0; g < PIX_W; g++) begin : g_bit
        localparam int B = PIX_W - 1 - g;

        logic [CELLS-1:0]                 zero_bits;
        logic [CELLS-1:0]                 one_bits;
        logic [MAX_WINDOW-1:0][CNT_W-1:0] cnt_next;
        logic [RANK_W-1:0]                c0;
        stage_t                           upd;

        // count candidates with a zero at this bit, one group per window row
        always_comb begin
            for (int i = 0; i < CELLS; i++) begin
                zero_bits[i] = st_reg[g].cand[i] & ~st_reg[g].val[i][B];
            end
            for (int r = 0; r < MAX_WINDOW; r++) begin
                cnt_next[r] = '0;
                for (int c = 0; c < MAX_WINDOW; c++) begin
                    cnt_next[r] = cnt_next[r] + CNT_W'(zero_bits[r*MAX_WINDOW+c]);
                end
            end
        end

        always_ff @(posedge clk) begin
            pc_reg[g]  <= st_reg[g];
            cnt_reg[g] <= cnt_next;
        end

        always_comb begin
            c0  = '0;
            upd = pc_reg[g];
            for (int r = 0; r < MAX_WINDOW; r++) begin
                c0 = c0 + RANK_W'(cnt_reg[g][r]);
            end
            for (int i = 0; i < CELLS; i++) begin
                one_bits[i] = pc_reg[g].val[i][B];
            end
            if (pc_reg[g].rank < c0) begin
                upd.res[B] = 1'b0;
                upd.cand   = pc_reg[g].cand & ~one_bits;
            end
            else begin
                upd.res[B] = 1'b1;
                upd.rank   = pc_reg[g].rank - c0;
                upd.cand   = pc_reg[g].cand & one_bits;
            end
        end

        always_ff @(posedge clk) begin
            st_reg[g+1] <= upd;
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                pc_vld_reg[g]   <= 1'b0;
                st_vld_reg[g+1] <= 1'b0;
            end
            else begin
                pc_vld_reg[g]   <= st_vld_reg[g];
                st_vld_reg[g+1] <= pc_vld_reg[g];
            end
        end
    end

    assign out_valid = st_vld_reg[PIX_W];
    assign out_tag   = st_reg[PIX_W].tag;
    assign out_value = st_reg[PIX_W].res;

endmodule

`default_nettype wire

### src/window_median_filter.sv
// Streaming k-by-k median filter over a zero-padded raster frame.
// Depends on wmf_pkg, the three channel interfaces and wmf_median_sel.
//
// Usage:
//   cfg      : register writes (0 window_size, 1 frame_width, 2 frame_height);
//              always ready, a write to one of them restarts the frame, other
//              indexes are dropped. Write only when idle.
//   in_chan  : one word per pixel in raster order (func = 0); once the frame is
//              complete, drain words (func = 1) push out the remaining results.
//              A drain word before frame end is taken and dropped.
//   out_chan : one median word per output pixel, frame_end on the last one.
// Throughput: one input word per clock while in_chan.ready is high. Output pixel m leaves for
//   input word m + a*W + a, a = k-1-floor(k/2). Rate is set by the line store, a
//   MAX_WIDTH-deep memory of (MAX_WINDOW-1) pixels per entry read and written at the
//   input column for each accepted word, and by the 17-stage bit-serial selector after it.
// Stall: results queue in a 32-word output FIFO; in_chan.ready drops once 32
//   results are queued or in flight, so nothing is lost.
// Reset: registers return to 3 / 640 / 480, counters to the frame start. The
//   line store is not cleared; out-of-frame taps are replaced by zero.
`default_nettype none

module window_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7
) (
    input  logic      clk,
    input  logic      rst_n,
    wmf_cfg_if.sink   cfg,
    wmf_pix_if.sink   in_chan,
    wmf_med_if.source out_chan
);
    import wmf_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > FRAME_W) ? WW : FRAME_W;
    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int KEW   = (KW > WIN_FIELD_W) ? KW : WIN_FIELD_W;
    localparam int DW    = KW + WW;
    localparam int CELLS = MAX_WINDOW * MAX_WINDOW;
    localparam int TAPS  = MAX_WINDOW - 1;
    localparam int YW    = ROW_W + 2;
    localparam int XW    = EW + 2;
    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CRW   = $clog2(OUT_DEPTH + 1);

    // configuration
    logic [WIN_FIELD_W-1:0] k_reg;
    logic [FRAME_W-1:0]     w_reg;
    logic [FRAME_W-1:0]     h_reg;
    logic                   cfg_hit;
    logic [KW-1:0]          k_eff;
    logic [WW-1:0]          w_eff;
    logic [FRAME_W-1:0]     h_eff;
    logic [KW-1:0]          ahead;
    logic [DW-1:0]          delay;

    // frame position
    logic [CW-1:0]          in_col_reg;
    logic [ROW_W-1:0]       in_row_reg;
    logic [CW-1:0]          out_col_reg;
    logic [ROW_W-1:0]       out_row_reg;
    logic [DW-1:0]          fill_reg;

    // accept stage
    logic                   acc;
    logic                   complete;
    logic                   shift;
    logic                   pix_ok;
    logic                   emit;
    logic                   last;
    logic                   in_wrap;
    logic                   out_wrap;
    logic [YW-1:0]          ya;
    logic [XW-1:0]          xa;
    logic [MAX_WINDOW-1:0]  rowok;
    logic [MAX_WINDOW-1:0]  colok;

    // line store stage
    logic [TAPS*PIX_W-1:0]  line_mem [MAX_WIDTH];
    logic [TAPS*PIX_W-1:0]  rd_data_reg;
    logic [TAPS*PIX_W-1:0]  rd_word;
    logic [TAPS*PIX_W-1:0]  wr_word;
    logic [TAPS*PIX_W-1:0]  fwd_word_reg;
    logic                   fwd_reg;
    logic                   s1_vld_reg;
    logic                   s1_emit_reg;
    logic                   s1_last_reg;
    logic [CW-1:0]          s1_addr_reg;
    logic [PIX_W-1:0]       s1_pix_reg;
    logic [MAX_WINDOW-1:0]  s1_rowok_reg;
    logic [MAX_WINDOW-1:0]  s1_colok_reg;

    // window stage: [column age][row tap]
    logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0][PIX_W-1:0] win_reg;
    logic                   s2_emit_reg;
    logic                   s2_last_reg;
    logic [MAX_WINDOW-1:0]  s2_rowok_reg;
    logic [MAX_WINDOW-1:0]  s2_colok_reg;
    logic [CELLS-1:0][PIX_W-1:0] cells;
    logic [CELLS-1:0]       low_tab [MAX_WINDOW+1];
    med_tag_t               s2_tag;

    // selector and output queue
    logic                   med_vld;
    med_tag_t               med_tag;
    logic [PIX_W-1:0]       med_value;
    out_word_t              fifo_mem [OUT_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CRW-1:0]         fifo_cnt_reg;
    logic [CRW-1:0]         credit_reg;
    logic                   pop;
    logic                   take;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_comb begin
        unique case (cfg_reg_t'(cfg.index))
            REG_WINDOW_SIZE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_hit = cfg.valid;
            default:                                            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            k_reg <= RESET_WINDOW;
            w_reg <= RESET_WIDTH;
            h_reg <= RESET_HEIGHT;
        end
        else if (cfg.valid) begin
            unique case (cfg_reg_t'(cfg.index))
                REG_WINDOW_SIZE:  k_reg <= cfg.data[WIN_FIELD_W-1:0];
                REG_FRAME_WIDTH:  w_reg <= cfg.data;
                REG_FRAME_HEIGHT: h_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (k_reg == '0) begin
            k_eff = KW'(1);
        end
        else if (KEW'(k_reg) > KEW'(MAX_WINDOW)) begin
            k_eff = KW'(MAX_WINDOW);
        end
        else begin
            k_eff = KW'(k_reg);
        end

        if (w_reg == '0) begin
            w_eff = WW'(1);
        end
        else if (EW'(w_reg) > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        else begin
            w_eff = WW'(w_reg);
        end

        if (h_reg == '0) begin
            h_eff = FRAME_W'(1);
        end
        else if (h_reg > FRAME_W'(FRAME_ROWS_MAX)) begin
            h_eff = FRAME_W'(FRAME_ROWS_MAX);
        end
        else begin
            h_eff = h_reg;
        end
    end

    assign ahead = k_eff - KW'(1) - (k_eff >> 1);
    assign delay = DW'(ahead) * DW'(w_eff) + DW'(ahead);

    // ---------------- accept stage ----------------
    assign in_chan.ready = (credit_reg < CRW'(OUT_DEPTH));
    assign acc      = in_chan.valid & in_chan.ready;
    assign complete = (in_row_reg >= h_eff);
    assign pix_ok   = ~in_chan.func & ~complete;
    assign shift    = ~(in_chan.func & ~complete);
    assign emit     = shift & (complete | (fill_reg == delay));
    assign out_wrap = (WW'(out_col_reg) + WW'(1) == w_eff);
    assign in_wrap  = (WW'(in_col_reg) + WW'(1) == w_eff);
    assign last     = emit & out_wrap & (out_row_reg == h_eff - FRAME_W'(1));

    // padding flags for the output pixel's window rows and columns
    assign ya = YW'(out_row_reg) + YW'(ahead);
    assign xa = XW'(out_col_reg) + XW'(ahead);

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            rowok[i] = (ya >= YW'(i)) && (ya - YW'(i) < YW'(h_eff));
            colok[i] = (xa >= XW'(i)) && (xa - XW'(i) < XW'(w_eff));
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fill_reg    <= '0;
        end
        else if (cfg_hit) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fill_reg    <= '0;
        end
        else if (acc && shift) begin
            if (last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                fill_reg    <= '0;
            end
            else begin
                if (in_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end
                else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
                if (pix_ok && fill_reg != delay) begin
                    fill_reg <= fill_reg + DW'(1);
                end
                if (emit) begin
                    if (out_wrap) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end
                    else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge clk) begin
        if (acc && shift) begin
            rd_data_reg <= line_mem[in_col_reg];
        end
    end

    always_ff @(posedge clk) begin
        if (s1_vld_reg) begin
            line_mem[s1_addr_reg] <= wr_word;
        end
    end

    // same-column write in the read cycle (width of one)
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fwd_reg <= 1'b0;
        end
        else begin
            fwd_reg <= acc && shift && s1_vld_reg && (s1_addr_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk) begin
        fwd_word_reg <= wr_word;
    end

    assign rd_word = fwd_reg ? fwd_word_reg : rd_data_reg;
    assign wr_word = {rd_word[(TAPS-1)*PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
        end
        else begin
            s1_vld_reg  <= acc && shift;
            s1_emit_reg <= acc && emit;
        end
    end

    always_ff @(posedge clk) begin
        s1_last_reg  <= last;
        s1_addr_reg  <= in_col_reg;
        s1_pix_reg   <= pix_ok ? in_chan.pixel_value : '0;
        s1_rowok_reg <= rowok;
        s1_colok_reg <= colok;
    end

    // ---------------- window ----------------
    always_ff @(posedge clk) begin
        if (s1_vld_reg) begin
            win_reg <= {win_reg[MAX_WINDOW-2:0], rd_word, s1_pix_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_emit_reg <= 1'b0;
        end
        else begin
            s2_emit_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk) begin
        s2_last_reg  <= s1_last_reg;
        s2_rowok_reg <= s1_rowok_reg;
        s2_colok_reg <= s1_colok_reg;
    end

    for (genvar kk = 0; kk <= MAX_WINDOW; kk++) begin : g_low
        localparam logic [CELL_LIM-1:0] LOW_MASK = low_fill_mask(MAX_WINDOW, kk);
        assign low_tab[kk] = LOW_MASK[CELLS-1:0];
    end

    // cells outside the k-by-k window are filled so the fixed middle rank holds
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                if (i < int'(k_eff) && j < int'(k_eff)) begin
                    cells[i*MAX_WINDOW+j] = (s2_rowok_reg[i] && s2_colok_reg[j]) ?
                                            win_reg[j][i] : '0;
                end
                else begin
                    cells[i*MAX_WINDOW+j] = low_tab[k_eff][i*MAX_WINDOW+j] ? '0 : '1;
                end
            end
        end
    end

    assign s2_tag.frame_end = s2_last_reg;

    wmf_median_sel #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_emit_reg),
        .in_tag    (s2_tag),
        .in_cells  (cells),
        .out_valid (med_vld),
        .out_tag   (med_tag),
        .out_value (med_value)
    );

    // ---------------- output queue ----------------
    assign pop  = out_chan.valid & out_chan.ready;
    assign take = acc & emit;

    always_ff @(posedge clk) begin
        if (med_vld) begin
            fifo_mem[wr_ptr_reg] <= '{median_value: med_value, frame_end: med_tag.frame_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end
        else begin
            if (med_vld) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CRW'(med_vld) - CRW'(pop);
            credit_reg   <= credit_reg + CRW'(take) - CRW'(pop);
        end
    end

    assign out_chan.valid        = (fifo_cnt_reg != '0);
    assign out_chan.median_value = fifo_mem[rd_ptr_reg].median_value;
    assign out_chan.frame_end    = fifo_mem[rd_ptr_reg].frame_end;

    // ---------------- checks ----------------
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CRW'(OUT_DEPTH))
        else $error("result credit above queue depth");

    a_queue_vs_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= credit_reg)
        else $error("queued results exceed issued credit");

    a_room_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        med_vld |-> (fifo_cnt_reg < CRW'(OUT_DEPTH)))
        else $error("selector result with output queue full");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= delay)
        else $error("fill count beyond window delay");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(in_col_reg) < w_eff) && (WW'(out_col_reg) < w_eff))
        else $error("column counter outside frame width");

endmodule

`default_nettype wire
